// ===== hw/rtl/rendezvous_message_engine_defines.svh =====
// assertion macros for the rendezvous message engine
`ifndef RENDEZVOUS_MESSAGE_ENGINE_DEFINES_SVH
`define RENDEZVOUS_MESSAGE_ENGINE_DEFINES_SVH

// implication checked on every edge outside reset
`define RME_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define RME_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/rme_pkg.sv =====
// ----------------------------------------------------------------------------
// rme_pkg
// types, codes and sizes shared by the rendezvous message engine
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int NumProc    = 16;
  localparam int PidBits    = $clog2(NumProc);
  localparam int LinkBits   = $clog2(NumProc + 1);
  localparam int FiltBits   = $clog2(NumProc + 2);
  localparam int HandleBits = 32;
  localparam int CntBits    = $clog2(NumProc + 1);

  localparam logic [LinkBits-1:0] NilLink = LinkBits'(NumProc);
  localparam logic [FiltBits-1:0] FiltAny = FiltBits'(NumProc);
  localparam logic [FiltBits-1:0] FiltInt = FiltBits'(NumProc + 1);

  typedef enum logic [1:0] {
    ACT_SEND = 2'd0,
    ACT_RECV = 2'd1,
    ACT_INT  = 2'd2,
    ACT_BAD  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_NAMED = 2'd0,
    KIND_ANY   = 2'd1,
    KIND_INT   = 2'd2,
    KIND_BAD   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_DELIVERED = 3'd0,
    ST_BLOCKED   = 3'd1,
    ST_PENDED    = 3'd2,
    ST_DEADLOCK  = 3'd3,
    ST_INVALID   = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]            action;
    logic [PidBits-1:0]    caller_pid;
    logic [1:0]            peer_kind;
    logic [PidBits-1:0]    peer_pid;
    logic [HandleBits-1:0] buffer_handle;
  } req_t;

  typedef struct packed {
    logic [2:0]            status;
    logic                  copy_valid;
    logic [HandleBits-1:0] copy_from_handle;
    logic [HandleBits-1:0] copy_to_handle;
    logic                  copy_is_irq;
    logic [PidBits-1:0]    msg_source_pid;
    logic                  wake_valid;
    logic [PidBits-1:0]    wake_pid;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CHAIN,
    S_SEND_DEC,
    S_ENQ_WALK,
    S_RECV_DEC,
    S_UNLINK,
    S_OUT
  } state_t;

  // datapath command codes
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RESULT,
    OP_CHAIN_INIT,
    OP_CHAIN_STEP,
    OP_SEND_DELIVER,
    OP_SEND_BLOCK,
    OP_ENQ_STEP,
    OP_INT,
    OP_RECV_INTPEND,
    OP_RECV_BLOCK,
    OP_UNLINK_INIT,
    OP_UNLINK_STEP,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic me_busy;
    logic int_match;
    logic chain_done;
    logic chain_hit;
    logic send_match;
    logic enq_done;
    logic int_pending;
    logic has_from;
    logic unlink_done;
  } stat_t;

endpackage

// ===== hw/rtl/rme_datapath.sv =====
// ----------------------------------------------------------------------------
// rme_datapath
// process tables, sender queues, chain and queue walkers, result register
// ----------------------------------------------------------------------------
module rme_datapath (
  input  logic          clk,
  input  logic          rst,
  input  rme_pkg::req_t req,
  input  rme_pkg::cmd_t cmd,
  output rme_pkg::stat_t stat,
  output rme_pkg::rsp_t rsp
);
  import rme_pkg::*;

  logic                  is_sending   [NumProc];
  logic                  is_receiving [NumProc];
  logic [PidBits-1:0]    send_target  [NumProc];
  logic [FiltBits-1:0]   recv_filter  [NumProc];
  logic [HandleBits-1:0] saved_handle [NumProc];
  logic                  int_pending  [NumProc];
  logic [LinkBits-1:0]   queue_head   [NumProc];
  logic [LinkBits-1:0]   queue_next   [NumProc];

  req_t               r;
  logic [PidBits-1:0] me;
  logic [PidBits-1:0] peer;
  logic [LinkBits-1:0] p;
  logic [CntBits-1:0] cnt;
  logic [PidBits-1:0] from;
  logic               chain_hit;
  logic               chain_end;

  logic [PidBits-1:0]  pp;
  logic [FiltBits-1:0] me_filt;
  logic [FiltBits-1:0] peer_filt;
  logic [LinkBits-1:0] me_link;
  logic [LinkBits-1:0] from_link;
  logic                bad;
  rsp_t                rsp_next;

  assign me        = r.caller_pid;
  assign peer      = r.peer_pid;
  assign pp        = p[PidBits-1:0];
  assign me_filt   = FiltBits'(me);
  assign me_link   = LinkBits'(me);
  assign from_link = LinkBits'(from);
  assign peer_filt = recv_filter[peer];

  // sender picked by a receive: queue head for any source, else the named peer
  assign from = (r.peer_kind == KIND_ANY) ? queue_head[me][PidBits-1:0] : peer;

  always_comb begin
    bad = 1'b0;
    if (r.action == ACT_BAD) begin
      bad = 1'b1;
    end else if (r.action == ACT_SEND) begin
      bad = (r.peer_kind != KIND_NAMED) || (peer == me);
    end else if (r.action == ACT_RECV) begin
      bad = (r.peer_kind == KIND_BAD) || ((r.peer_kind == KIND_NAMED) && (peer == me));
    end
  end

  always_comb begin
    stat.bad         = bad;
    stat.me_busy     = is_sending[me] || is_receiving[me];
    stat.int_match   = is_receiving[me] && (recv_filter[me] == FiltInt ||
                       recv_filter[me] == FiltAny);
    stat.chain_done  = chain_end;
    stat.chain_hit   = chain_hit;
    stat.send_match  = is_receiving[peer] && (peer_filt == me_filt || peer_filt == FiltAny);
    stat.enq_done    = (p == NilLink) || (queue_next[pp] == NilLink) ||
                       (cnt == CntBits'(NumProc));
    stat.int_pending = int_pending[me] && (r.peer_kind != KIND_NAMED);
    stat.has_from    = (r.peer_kind == KIND_ANY) ? (queue_head[me] != NilLink) :
                       ((r.peer_kind == KIND_NAMED) && is_sending[peer] &&
                        send_target[peer] == me);
    stat.unlink_done = (p == NilLink) || (cnt == CntBits'(NumProc));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumProc; i++) begin
        is_sending[i]   <= 1'b0;
        is_receiving[i] <= 1'b0;
        send_target[i]  <= '0;
        recv_filter[i]  <= '0;
        int_pending[i]  <= 1'b0;
        queue_head[i]   <= NilLink;
        queue_next[i]   <= NilLink;
      end
      chain_hit <= 1'b0;
      chain_end <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_CHAIN_INIT: begin
          p         <= LinkBits'(peer);
          cnt       <= '0;
          chain_hit <= 1'b0;
          chain_end <= 1'b0;
        end
        OP_CHAIN_STEP: begin
          if (cnt == CntBits'(NumProc) || !is_sending[pp]) begin
            chain_end <= 1'b1;
          end else if (send_target[pp] == me) begin
            chain_end <= 1'b1;
            chain_hit <= 1'b1;
          end else begin
            p   <= LinkBits'(send_target[pp]);
            cnt <= cnt + 1'b1;
          end
        end
        OP_SEND_DELIVER: begin
          is_receiving[peer] <= 1'b0;
          recv_filter[peer]  <= '0;
        end
        OP_SEND_BLOCK: begin
          is_sending[me]   <= 1'b1;
          send_target[me]  <= peer;
          saved_handle[me] <= r.buffer_handle;
          queue_next[me]   <= NilLink;
          if (queue_head[peer] == NilLink) begin
            queue_head[peer] <= me_link;
            p <= NilLink;
          end else begin
            p <= queue_head[peer];
          end
          cnt <= '0;
        end
        OP_ENQ_STEP: begin
          if (p != NilLink) begin
            if (queue_next[pp] == NilLink || cnt == CntBits'(NumProc)) begin
              queue_next[pp] <= me_link;
              p <= NilLink;
            end else begin
              p   <= queue_next[pp];
              cnt <= cnt + 1'b1;
            end
          end
        end
        OP_INT: begin
          if (stat.int_match) begin
            is_receiving[me] <= 1'b0;
            recv_filter[me]  <= '0;
            int_pending[me]  <= 1'b0;
          end else begin
            int_pending[me]  <= 1'b1;
          end
        end
        OP_RECV_INTPEND: begin
          int_pending[me] <= 1'b0;
        end
        OP_RECV_BLOCK: begin
          is_receiving[me] <= 1'b1;
          recv_filter[me]  <= (r.peer_kind == KIND_ANY) ? FiltAny :
                              (r.peer_kind == KIND_INT) ? FiltInt : FiltBits'(peer);
          saved_handle[me] <= r.buffer_handle;
        end
        OP_UNLINK_INIT: begin
          is_sending[from]  <= 1'b0;
          send_target[from] <= '0;
          cnt <= '0;
          if (queue_head[me] == from_link) begin
            queue_head[me]   <= queue_next[from];
            queue_next[from] <= NilLink;
            p <= NilLink;
          end else begin
            p <= queue_head[me];
          end
        end
        OP_UNLINK_STEP: begin
          if (p != NilLink && cnt != CntBits'(NumProc)) begin
            if (queue_next[pp] == from_link) begin
              queue_next[pp]   <= queue_next[from];
              queue_next[from] <= NilLink;
              p <= NilLink;
            end else begin
              p   <= queue_next[pp];
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      r <= req;
    end
  end

  always_comb begin
    rsp_next        = '0;
    rsp_next.status = cmd.status;
    case (cmd.op)
      OP_SEND_DELIVER: begin
        rsp_next.copy_valid       = 1'b1;
        rsp_next.copy_from_handle = r.buffer_handle;
        rsp_next.copy_to_handle   = saved_handle[peer];
        rsp_next.msg_source_pid   = me;
        rsp_next.wake_valid       = 1'b1;
        rsp_next.wake_pid         = peer;
      end
      OP_INT: begin
        if (stat.int_match) begin
          rsp_next.copy_valid     = 1'b1;
          rsp_next.copy_to_handle = saved_handle[me];
          rsp_next.copy_is_irq    = 1'b1;
          rsp_next.wake_valid     = 1'b1;
          rsp_next.wake_pid       = me;
        end
      end
      OP_RECV_INTPEND: begin
        rsp_next.copy_valid     = 1'b1;
        rsp_next.copy_to_handle = r.buffer_handle;
        rsp_next.copy_is_irq    = 1'b1;
      end
      OP_UNLINK_INIT: begin
        rsp_next.copy_valid       = 1'b1;
        rsp_next.copy_from_handle = saved_handle[from];
        rsp_next.copy_to_handle   = r.buffer_handle;
        rsp_next.msg_source_pid   = from;
        rsp_next.wake_valid       = 1'b1;
        rsp_next.wake_pid         = from;
      end
      default: begin
      end
    endcase
  end

  // result register, written once per transaction by the deciding command
  always_ff @(posedge clk) begin
    case (cmd.op) inside
      OP_RESULT, OP_SEND_DELIVER, OP_SEND_BLOCK, OP_INT, OP_RECV_INTPEND, OP_RECV_BLOCK,
      OP_UNLINK_INIT: begin
        rsp <= rsp_next;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/rme_ctrl.sv =====
// ----------------------------------------------------------------------------
// rme_ctrl
// request sequencer: decode, chain walk, queue walks, result handshake
// ----------------------------------------------------------------------------
module rme_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  rme_pkg::req_t  req,
  input  rme_pkg::stat_t stat,
  output rme_pkg::cmd_t  cmd
);
  import rme_pkg::*;

  state_t state, state_next;
  logic   act_send;
  logic   act_int;
  logic   out_hold, out_hold_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      act_send <= 1'b0;
      act_int  <= 1'b0;
      out_hold <= 1'b0;
    end else begin
      state    <= state_next;
      out_hold <= out_hold_next;
      if (state == S_IDLE && in_valid) begin
        act_send <= (req.action == ACT_SEND);
        act_int  <= (req.action == ACT_INT);
      end
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = out_hold;

  always_comb begin
    state_next    = state;
    out_hold_next = out_hold && out_stall;
    cmd.op        = OP_NONE;
    cmd.status    = ST_INVALID;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.status = ST_INVALID;
        if (stat.bad) begin
          cmd.op     = OP_RESULT;
          state_next = S_OUT;
        end else if (act_int) begin
          cmd.op     = OP_INT;
          cmd.status = stat.int_match ? ST_DELIVERED : ST_PENDED;
          state_next = S_OUT;
        end else if (stat.me_busy) begin
          cmd.op     = OP_RESULT;
          state_next = S_OUT;
        end else if (act_send) begin
          cmd.op     = OP_CHAIN_INIT;
          state_next = S_CHAIN;
        end else if (stat.int_pending) begin
          cmd.op     = OP_RECV_INTPEND;
          cmd.status = ST_DELIVERED;
          state_next = S_OUT;
        end else begin
          state_next = S_RECV_DEC;
        end
      end
      S_CHAIN: begin
        if (stat.chain_done) begin
          state_next = S_SEND_DEC;
        end else begin
          cmd.op = OP_CHAIN_STEP;
        end
      end
      S_SEND_DEC: begin
        if (stat.chain_hit) begin
          cmd.op     = OP_RESULT;
          cmd.status = ST_DEADLOCK;
          state_next = S_OUT;
        end else if (stat.send_match) begin
          cmd.op     = OP_SEND_DELIVER;
          cmd.status = ST_DELIVERED;
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_SEND_BLOCK;
          cmd.status = ST_BLOCKED;
          state_next = S_ENQ_WALK;
        end
      end
      S_ENQ_WALK: begin
        cmd.status = ST_BLOCKED;
        if (stat.enq_done) begin
          cmd.op     = OP_ENQ_STEP;
          state_next = S_OUT;
        end else begin
          cmd.op = OP_ENQ_STEP;
        end
      end
      S_RECV_DEC: begin
        if (stat.has_from) begin
          cmd.op     = OP_UNLINK_INIT;
          cmd.status = ST_DELIVERED;
          state_next = S_UNLINK;
        end else begin
          cmd.op     = OP_RECV_BLOCK;
          cmd.status = ST_BLOCKED;
          state_next = S_OUT;
        end
      end
      S_UNLINK: begin
        cmd.status = ST_DELIVERED;
        if (stat.unlink_done) begin
          state_next = S_OUT;
        end else begin
          cmd.op = OP_UNLINK_STEP;
        end
      end
      S_OUT: begin
        cmd.op = OP_OUT;
        if (!out_hold || !out_stall) begin
          out_hold_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rme_outreg.sv =====
// ----------------------------------------------------------------------------
// rme_outreg
// holds the finished result while the receiver stalls
// ----------------------------------------------------------------------------
module rme_outreg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  rme_pkg::rsp_t din,
  input  logic          hold,
  output rme_pkg::rsp_t dout
);
  import rme_pkg::*;

  rsp_t   buf_q;
  logic   have;

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else begin
      have <= 1'b1;
    end
    if (load && !hold) begin
      buf_q <= din;
    end
  end

  assign dout = have ? buf_q : '0;

endmodule

// ===== hw/rtl/rendezvous_message_engine.sv =====
// time from accepted request to result is set by the deadlock chain walk and the
// sender queue walks, which visit one entry per cycle
// throughput: one request at a time; next accepted in the cycle the result shows
// reset: synchronous, clears all process flags and empties every sender queue
// ----------------------------------------------------------------------------
// rendezvous_message_engine
// synchronous send/receive message engine with interrupt notification
// ----------------------------------------------------------------------------
module rendezvous_message_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  rme_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rme_pkg::rsp_t out_data
);
  import rme_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  rsp_t  rsp;

  rme_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .req       (in_data),
    .stat      (stat),
    .cmd       (cmd)
  );

  rme_datapath u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (in_data),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

  rme_outreg u_out (
    .clk  (clk),
    .rst  (rst),
    .load (cmd.op == OP_OUT),
    .din  (rsp),
    .hold (out_valid && out_stall),
    .dout (out_data)
  );

endmodule

// ===== hw/rtl/rme_checker.sv =====
// ----------------------------------------------------------------------------
// rme_checker
// port-level checks on the rendezvous message engine
// ----------------------------------------------------------------------------
`include "rendezvous_message_engine_defines.svh"

module rme_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input rme_pkg::rsp_t out_data
);
  import rme_pkg::*;

  `RME_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `RME_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && !in_stall, in_stall)
  `RME_ASSERT_IMP(a_copy_fields, clk, rst, out_valid && !out_data.copy_valid, out_data.copy_to_handle == '0)

endmodule

bind rendezvous_message_engine rme_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
